/* rtl/roman_numeral_encoder_unit_macros.svh */
// Assertion helpers for the Roman numeral encoder.
// Each helper expects clk and arst_n in scope.
`ifndef ROMAN_NUMERAL_ENCODER_UNIT_MACROS_SVH
`define ROMAN_NUMERAL_ENCODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define RNE_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle check");

// Next-cycle implication.
`define RNE_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle check");

`endif

/* rtl/rne_pkg.sv */
`default_nettype none
package rne_pkg;

	localparam int unsigned ValueW = 12;
	localparam int unsigned CharW  = 8;
	localparam int unsigned IdxW   = 4;

	// Index of the final table entry (weight one).
	localparam logic [IdxW-1:0] LastIdx = 4'd12;

	localparam logic [CharW-1:0] ChM       = 8'h4D;
	localparam logic [CharW-1:0] ChD       = 8'h44;
	localparam logic [CharW-1:0] ChC       = 8'h43;
	localparam logic [CharW-1:0] ChL       = 8'h4C;
	localparam logic [CharW-1:0] ChX       = 8'h58;
	localparam logic [CharW-1:0] ChV       = 8'h56;
	localparam logic [CharW-1:0] ChI       = 8'h49;
	localparam logic [CharW-1:0] ChNewline = 8'h0A;

	typedef struct packed {
		logic [ValueW-1:0] weight;
		logic [CharW-1:0]  first;
		logic [CharW-1:0]  second;
		logic              pair;
	} entry_t;

	typedef struct packed {
		logic              ge;
		logic [ValueW-1:0] diff;
		logic [CharW-1:0]  first;
		logic [CharW-1:0]  second;
		logic              pair;
	} alu_res_t;

	function automatic entry_t rne_entry(input logic [IdxW-1:0] idx);
		entry_t e;
		e = '0;
		case (idx)
			4'd0: begin e.weight = 12'd1000; e.first = ChM; e.second = '0;  e.pair = 1'b0; end
			4'd1: begin e.weight = 12'd900;  e.first = ChC; e.second = ChM; e.pair = 1'b1; end
			4'd2: begin e.weight = 12'd500;  e.first = ChD; e.second = '0;  e.pair = 1'b0; end
			4'd3: begin e.weight = 12'd400;  e.first = ChC; e.second = ChD; e.pair = 1'b1; end
			4'd4: begin e.weight = 12'd100;  e.first = ChC; e.second = '0;  e.pair = 1'b0; end
			4'd5: begin e.weight = 12'd90;   e.first = ChX; e.second = ChC; e.pair = 1'b1; end
			4'd6: begin e.weight = 12'd50;   e.first = ChL; e.second = '0;  e.pair = 1'b0; end
			4'd7: begin e.weight = 12'd40;   e.first = ChX; e.second = ChL; e.pair = 1'b1; end
			4'd8: begin e.weight = 12'd10;   e.first = ChX; e.second = '0;  e.pair = 1'b0; end
			4'd9: begin e.weight = 12'd9;    e.first = ChI; e.second = ChX; e.pair = 1'b1; end
			4'd10: begin e.weight = 12'd5;   e.first = ChV; e.second = '0;  e.pair = 1'b0; end
			4'd11: begin e.weight = 12'd4;   e.first = ChI; e.second = ChV; e.pair = 1'b1; end
			default: begin e.weight = 12'd1; e.first = ChI; e.second = '0;  e.pair = 1'b0; end
		endcase
		return e;
	endfunction

endpackage
`default_nettype wire

/* rtl/roman_numeral_encoder_unit.sv */
// After a value word is taken, the sequencer steps past the table entries that do not
//   match; the first character is registered once the output register is free.
// A new value word is taken only after the previous run has closed with its newline;
//   the single compare/subtract unit steps the 13-entry table.
// Reset: arst_n low clears the sequencer to idle and drops the output valid at once.
`default_nettype none
module roman_numeral_encoder_unit
	import rne_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [ValueW-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [CharW-1:0]       character,
	output logic                   last
);

	// Sequencer states: idle waits for a word, run walks the table.
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_RUN  = 2'b10
	} state_t;

	state_t            state_q;
	logic [ValueW-1:0] rest_q;
	logic [IdxW-1:0]   idx_q;
	logic              phase_q;   // second half of a subtractive pair
	logic              out_valid_q;
	logic [CharW-1:0]  char_q;
	logic              last_q;

	alu_res_t          alu;
	logic              out_free;
	logic              in_take;
	logic              emit;

	rne_alu u_alu (
		.rest (rest_q),
		.idx  (idx_q),
		.res  (alu)
	);

	// Output register frees up when empty or when its word is taken this cycle.
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE);
	assign in_take  = in_valid && !in_stall;
	// A symbol or the closing newline is loaded into the output register this cycle.
	assign emit     = (state_q == S_RUN) && out_free && (alu.ge || (idx_q == LastIdx));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			idx_q       <= '0;
			phase_q     <= 1'b0;
		end else begin
			// Hold a stalled word, load a new one when the sequencer emits.
			out_valid_q <= emit || (out_valid_q && out_stall);
			case (state_q)
				S_IDLE: begin
					if (in_take) begin
						state_q <= S_RUN;
						idx_q   <= '0;
						phase_q <= 1'b0;
					end
				end
				S_RUN: begin
					if (alu.ge) begin
						// Emit one symbol; advance the remainder after the last symbol of the entry.
						if (out_free) begin
							if (alu.pair && !phase_q) begin
								phase_q <= 1'b1;
							end else begin
								phase_q <= 1'b0;
							end
						end
					end else if (idx_q == LastIdx) begin
						// Remainder is zero: close the run with a newline.
						if (out_free) begin
							state_q <= S_IDLE;
						end
					end else begin
						idx_q <= idx_q + 1'b1;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Payload registers: no reset needed.
	always_ff @(posedge clk) begin
		if (in_take) begin
			rest_q <= value;
		end else if (state_q == S_RUN && out_free) begin
			if (alu.ge) begin
				char_q <= (alu.pair && phase_q) ? alu.second : alu.first;
				last_q <= 1'b0;
				if (!(alu.pair && !phase_q)) begin
					rest_q <= alu.diff;
				end
			end else if (idx_q == LastIdx) begin
				char_q <= ChNewline;
				last_q <= 1'b1;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign character = char_q;
	assign last      = last_q;

endmodule
`default_nettype wire

/* rtl/rne_alu.sv */
`default_nettype none
// Shared compare/subtract against the selected table weight.
module rne_alu
	import rne_pkg::*;
(
	input  wire logic [ValueW-1:0] rest,
	input  wire logic [IdxW-1:0]   idx,
	output alu_res_t               res
);

	entry_t ent;

	always_comb begin
		ent        = rne_entry(idx);
		res.ge     = (rest >= ent.weight);
		res.diff   = rest - ent.weight;
		res.first  = ent.first;
		res.second = ent.second;
		res.pair   = ent.pair;
	end

endmodule
`default_nettype wire

/* rtl/rne_checker.sv */
`default_nettype none
`include "roman_numeral_encoder_unit_macros.svh"
module rne_checker
	import rne_pkg::*;
(
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              in_valid,
	input wire logic              in_stall,
	input wire logic [ValueW-1:0] value,
	input wire logic              out_valid,
	input wire logic              out_stall,
	input wire logic [CharW-1:0]  character,
	input wire logic              last
);

	logic legal_char;
	logic value_seen;

	assign legal_char = (character == ChM) || (character == ChD) || (character == ChC) ||
		(character == ChL) || (character == ChX) || (character == ChV) ||
		(character == ChI) || (character == ChNewline);
	assign value_seen = ^value || 1'b1;

	// A stalled output word holds.
	`RNE_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(character) && $stable(last))
	// Only numeral symbols and the newline appear.
	`RNE_ASSERT_NOW(a_legal_char, out_valid, legal_char)
	// The last mark rides on the newline and nowhere else.
	`RNE_ASSERT_NOW(a_last_nl, out_valid, last == (character == ChNewline))
	// A taken value word keeps the input busy while it converts.
	`RNE_ASSERT_NEXT(a_busy, in_valid && !in_stall && value_seen, in_stall)

endmodule

bind roman_numeral_encoder_unit rne_checker u_rne_checker (.*);
`default_nettype wire
